@@ rtl/irpd_pkg.sv @@
// ----------------------------------------------------------------------------
// irpd_pkg
// Shared types, constants and register indexes of the ir pulse decoder.
// ----------------------------------------------------------------------------
package irpd_pkg;

   localparam int STAMP_W     = 16;
   localparam int PACKET_BITS = 13;
   localparam int CNT_W       = $clog2(PACKET_BITS + 2);
   localparam int WORD_W      = 13;
   localparam int ID_W        = 7;
   localparam int ID_LSB      = 6;
   localparam int KIND_W      = 3;
   localparam int CSR_INDEX_W = 3;

   localparam logic [STAMP_W-1:0] STAMP_MASK = 16'hFFFF;

   localparam logic [ID_W-1:0] KIND_ID_FIRST = 7'd53;
   localparam logic [ID_W-1:0] KIND_ID_LAST  = 7'd58;
   localparam logic [ID_W-1:0] KIND_ID_BIAS  = 7'd52;

   localparam logic [STAMP_W-1:0] HEADER_MIN_RST = 16'd2000;
   localparam logic [STAMP_W-1:0] HEADER_MAX_RST = 16'd2800;
   localparam logic [STAMP_W-1:0] ONE_MIN_RST    = 16'd1000;
   localparam logic [STAMP_W-1:0] ONE_MAX_RST    = 16'd1400;
   localparam logic [STAMP_W-1:0] ZERO_MIN_RST   = 16'd400;
   localparam logic [STAMP_W-1:0] ZERO_MAX_RST   = 16'd800;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_HEADER_MIN = 3'd0,
      CSR_HEADER_MAX = 3'd1,
      CSR_ONE_MIN    = 3'd2,
      CSR_ONE_MAX    = 3'd3,
      CSR_ZERO_MIN   = 3'd4,
      CSR_ZERO_MAX   = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [STAMP_W-1:0] header_min;
      logic [STAMP_W-1:0] header_max;
      logic [STAMP_W-1:0] one_min;
      logic [STAMP_W-1:0] one_max;
      logic [STAMP_W-1:0] zero_min;
      logic [STAMP_W-1:0] zero_max;
   } window_cfg_type;

   typedef struct packed {
      logic is_header;
      logic is_one;
      logic is_zero;
   } pulse_class_type;

endpackage

@@ rtl/ir_pulse_width_packet_decoder.sv @@
// path: a packet's last bit pulse raises rsp_valid after its acceptance edge
// (input register, then result register)
// throughput: one pulse transaction per cycle, set by the single input register stage,
// which holds whenever a staged pulse meets a finished packet still waiting at rsp
// reset: synchronous, active high; windows return to defaults, decoder goes idle
// ----------------------------------------------------------------------------
// ir_pulse_width_packet_decoder
// Decodes pulse-width coded infrared packets from captured edge stamps.
// ----------------------------------------------------------------------------
module ir_pulse_width_packet_decoder import irpd_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   // pulse transactions
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [STAMP_W-1:0]     req_fall_stamp,
   input  logic [STAMP_W-1:0]     req_rise_stamp,
   // packet transactions
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [WORD_W-1:0]      rsp_packet_word,
   output logic [ID_W-1:0]        rsp_sender_id,
   output logic [KIND_W-1:0]      rsp_field_kind,
   // window configuration
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [STAMP_W-1:0]     csr_wdata
);

   window_cfg_type  cfg;
   pulse_class_type pulse_class;

   // input register stage
   logic               in_valid_ff, in_valid_in;
   logic [STAMP_W-1:0] fall_ff, rise_ff;
   logic               step;
   logic               accept;

   // the staged pulse is processed when the result register is free or draining
   assign step      = in_valid_ff && (!rsp_valid || rsp_ready);
   assign req_ready = !in_valid_ff || step;
   assign accept    = req_valid && req_ready;

   always_comb begin
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // stamps need no reset, they only matter while in_valid_ff is set
   always_ff @(posedge clock) begin
      if (accept) begin
         fall_ff <= req_fall_stamp;
         rise_ff <= req_rise_stamp;
      end
   end

   irpd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // width and window match of the staged pulse
   irpd_classify u_classify (
      .fall_stamp  (fall_ff),
      .rise_stamp  (rise_ff),
      .cfg         (cfg),
      .pulse_class (pulse_class)
   );

   // packet assembly and the result register
   irpd_assembler u_assembler (
      .clock           (clock),
      .reset           (reset),
      .step            (step),
      .pulse_class     (pulse_class),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_packet_word (rsp_packet_word),
      .rsp_sender_id   (rsp_sender_id),
      .rsp_field_kind  (rsp_field_kind)
   );

endmodule

@@ rtl/irpd_csr.sv @@
// ----------------------------------------------------------------------------
// irpd_csr
// Window configuration registers with a plain indexed write port.
// ----------------------------------------------------------------------------
module irpd_csr import irpd_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [STAMP_W-1:0]     csr_wdata,
   output window_cfg_type         cfg
);

   window_cfg_type cfg_ff;
   window_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_HEADER_MIN: cfg_in.header_min = csr_wdata;
            CSR_HEADER_MAX: cfg_in.header_max = csr_wdata;
            CSR_ONE_MIN:    cfg_in.one_min    = csr_wdata;
            CSR_ONE_MAX:    cfg_in.one_max    = csr_wdata;
            CSR_ZERO_MIN:   cfg_in.zero_min   = csr_wdata;
            CSR_ZERO_MAX:   cfg_in.zero_max   = csr_wdata;
            default:        cfg_in = cfg_ff;  // unused indexes are dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header_min <= HEADER_MIN_RST;
         cfg_ff.header_max <= HEADER_MAX_RST;
         cfg_ff.one_min    <= ONE_MIN_RST;
         cfg_ff.one_max    <= ONE_MAX_RST;
         cfg_ff.zero_min   <= ZERO_MIN_RST;
         cfg_ff.zero_max   <= ZERO_MAX_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/irpd_classify.sv @@
// ----------------------------------------------------------------------------
// irpd_classify
// Pulse width from two timer stamps and inclusive window tests.
// ----------------------------------------------------------------------------
module irpd_classify import irpd_pkg::*; (
   input  logic [STAMP_W-1:0] fall_stamp,
   input  logic [STAMP_W-1:0] rise_stamp,
   input  window_cfg_type     cfg,
   output pulse_class_type    pulse_class
);

   logic [STAMP_W-1:0] width;

   // wrapped case is 0xffff - fall + rise, one short of a true modular difference
   always_comb begin
      if (rise_stamp >= fall_stamp) begin
         width = rise_stamp - fall_stamp;
      end else begin
         width = STAMP_MASK - fall_stamp + rise_stamp;
      end
   end

   assign pulse_class.is_header = (width >= cfg.header_min) && (width <= cfg.header_max);
   assign pulse_class.is_one    = (width >= cfg.one_min)    && (width <= cfg.one_max);
   assign pulse_class.is_zero   = (width >= cfg.zero_min)   && (width <= cfg.zero_max);

endmodule

@@ rtl/irpd_assembler.sv @@
// ----------------------------------------------------------------------------
// irpd_assembler
// Packet shift register, bit counter and registered result stage.
// ----------------------------------------------------------------------------
module irpd_assembler import irpd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  pulse_class_type       pulse_class,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic [WORD_W-1:0]     rsp_packet_word,
   output logic [ID_W-1:0]       rsp_sender_id,
   output logic [KIND_W-1:0]     rsp_field_kind
);

   logic [PACKET_BITS-1:0] shift_ff, shift_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   valid_ff, valid_in;
   logic [WORD_W-1:0]      word_ff, word_in;
   logic [ID_W-1:0]        id_ff, id_in;
   logic [KIND_W-1:0]      kind_ff, kind_in;

   logic [PACKET_BITS-1:0] shifted;
   logic                   emit;

   assign shifted = {shift_ff[PACKET_BITS-2:0], pulse_class.is_one};

   always_comb begin
      shift_in = shift_ff;
      count_in = count_ff;
      emit     = 1'b0;
      if (step) begin
         if (pulse_class.is_header) begin
            shift_in = '0;
            count_in = CNT_W'(1);
         end else if (count_ff != '0 && count_ff <= CNT_W'(PACKET_BITS)) begin
            if (!pulse_class.is_one && !pulse_class.is_zero) begin
               shift_in = '0;
               count_in = '0;
            end else if (count_ff == CNT_W'(PACKET_BITS)) begin
               emit     = 1'b1;
               shift_in = '0;
               count_in = '0;
            end else begin
               shift_in = shifted;
               count_in = count_ff + CNT_W'(1);
            end
         end
      end
   end

   always_comb begin
      word_in = shifted[WORD_W-1:0];
      id_in   = shifted[ID_LSB +: ID_W];
      if (id_in inside {[KIND_ID_FIRST:KIND_ID_LAST]}) begin
         kind_in = KIND_W'(id_in - KIND_ID_BIAS);
      end else begin
         kind_in = '0;
      end
   end

   always_comb begin
      if (emit) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= '0;
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         shift_ff <= shift_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         word_ff <= word_in;
         id_ff   <= id_in;
         kind_ff <= kind_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_packet_word = word_ff;
   assign rsp_sender_id   = id_ff;
   assign rsp_field_kind  = kind_ff;

endmodule
